@@ design/mskef_pkg.sv @@
// Shared types and constants for the MIDI seek key-event filter.
// No dependencies; every other design file but mskef_ram imports this package.
package mskef_pkg;

    // Field positions and message kinds of a stream event word.
    localparam logic [7:0] SHORT_MSG_TYPE  = 8'h00;
    localparam logic [3:0] STATUS_CONTROL  = 4'hB;
    localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
    localparam logic [3:0] STATUS_PRESSURE = 4'hD;
    localparam logic [3:0] STATUS_PITCH    = 4'hE;

    localparam logic [7:0] TEMPO_CODE_RESET = 8'h01;

    // Classification made by the front end, carried out by the back end.
    typedef enum logic [2:0] {
        KIND_DROP,
        KIND_START,
        KIND_CONTROL,
        KIND_PROGRAM,
        KIND_PRESSURE,
        KIND_PITCH,
        KIND_TEMPO
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [7:0]  data1;
        logic [31:0] word;
    } item_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

@@ design/mskef_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module mskef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 120,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/mskef_front.sv @@
// Front end: holds the tempo code register and classifies each incoming word.
// Depends on mskef_pkg.
module mskef_front
    import mskef_pkg::*;
#(
    parameter int NUM_CONTROLLERS = 120
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic [31:0] event_word,
    input  logic        seek_start,
    output item_t       item
);

    logic [7:0] tempo_code_reg;
    logic [7:0] ev_type;
    logic [3:0] status_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_code_reg <= TEMPO_CODE_RESET;
        end
        else if (cfg_write_en)
        begin
            tempo_code_reg <= cfg_write_data;
        end
    end

    assign ev_type   = event_word[31:24];
    assign status_hi = event_word[7:4];

    always_comb
    begin
        item.channel = event_word[3:0];
        item.data1   = event_word[15:8];
        item.word    = event_word;
        item.kind    = KIND_DROP;
        // Short messages win over tempo, so a tempo code of zero never matches.
        priority if (seek_start)
        begin
            item.kind = KIND_START;
        end
        else if (ev_type == SHORT_MSG_TYPE)
        begin
            priority if (status_hi == STATUS_CONTROL)
            begin
                if (event_word[15:8] < 8'(NUM_CONTROLLERS))
                begin
                    item.kind = KIND_CONTROL;
                end
            end
            else if (status_hi == STATUS_PROGRAM)
            begin
                item.kind = KIND_PROGRAM;
            end
            else if (status_hi == STATUS_PRESSURE)
            begin
                item.kind = KIND_PRESSURE;
            end
            else if (status_hi == STATUS_PITCH)
            begin
                item.kind = KIND_PITCH;
            end
            else
            begin
                item.kind = KIND_DROP;
            end
        end
        else if (ev_type == tempo_code_reg)
        begin
            item.kind = KIND_TEMPO;
        end
        else
        begin
            item.kind = KIND_DROP;
        end
    end

endmodule

@@ design/mskef_queue.sv @@
// Two-entry queue of classified words between the front and back ends.
// Depends on mskef_pkg.
module mskef_queue
    import mskef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       push_item,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    item_t      slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/mskef_back.sv @@
// Back end: seen-bitmaps, controller bitmap RAM, keep decision and output register.
// Depends on mskef_pkg and mskef_ram.
module mskef_back
    import mskef_pkg::*;
#(
    parameter int NUM_CONTROLLERS = 120
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        keep,
    output logic [31:0] event_out
);

    localparam int CTRL_AW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

    // Stage holding the word whose bitmap row is being read.
    logic                       stage_valid_reg;
    item_t                      stage_item_reg;
    logic                       fire;
    logic                       load;
    logic                       out_ready;

    // Per-channel bitmaps and per-row valid bits for the controller RAM.
    logic [15:0]                program_seen_reg;
    logic [15:0]                pressure_seen_reg;
    logic [15:0]                pitch_seen_reg;
    logic                       tempo_seen_reg;
    logic [NUM_CONTROLLERS-1:0] row_valid_reg;

    // Last RAM write, used to bypass a read that raced with it.
    logic                       last_wr_valid_reg;
    logic [CTRL_AW-1:0]         last_wr_addr_reg;
    logic [15:0]                last_wr_data_reg;

    logic [CTRL_AW-1:0]         stage_addr;
    logic [15:0]                ram_rd_data;
    logic [15:0]                ctrl_map;
    logic [15:0]                chan_bit;
    logic                       ram_wr_en;
    logic [15:0]                ram_wr_data;
    logic                       keep_now;
    logic                       stage_row_valid;

    logic                       out_valid_reg;
    logic                       keep_reg;
    logic [31:0]                event_out_reg;

    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = stage_valid_reg && out_ready;
    assign load      = head.valid && (!stage_valid_reg || fire);
    assign pop       = load;

    assign stage_addr      = stage_item_reg.data1[CTRL_AW-1:0];
    assign chan_bit        = 16'd1 << stage_item_reg.channel;
    assign stage_row_valid = (stage_item_reg.kind == KIND_CONTROL) && row_valid_reg[stage_addr];

    mskef_ram #(
        .WIDTH (16),
        .DEPTH (NUM_CONTROLLERS),
        .AW    (CTRL_AW)
    ) u_ctrl_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (stage_addr),
        .wr_data (ram_wr_data),
        .rd_en   (load),
        .rd_addr (head.item.data1[CTRL_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        // A row that has not been written since the last clear reads as zero.
        if (!stage_row_valid)
        begin
            ctrl_map = 16'd0;
        end
        else if (last_wr_valid_reg && (last_wr_addr_reg == stage_addr))
        begin
            ctrl_map = last_wr_data_reg;
        end
        else
        begin
            ctrl_map = ram_rd_data;
        end

        ram_wr_en   = fire && (stage_item_reg.kind == KIND_CONTROL);
        ram_wr_data = ctrl_map | chan_bit;

        unique case (stage_item_reg.kind)
            KIND_START:    keep_now = 1'b1;
            KIND_CONTROL:  keep_now = ((ctrl_map & chan_bit) == 16'd0);
            KIND_PROGRAM:  keep_now = ((program_seen_reg & chan_bit) == 16'd0);
            KIND_PRESSURE: keep_now = ((pressure_seen_reg & chan_bit) == 16'd0);
            KIND_PITCH:    keep_now = ((pitch_seen_reg & chan_bit) == 16'd0);
            KIND_TEMPO:    keep_now = !tempo_seen_reg;
            default:       keep_now = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            program_seen_reg  <= 16'd0;
            pressure_seen_reg <= 16'd0;
            pitch_seen_reg    <= 16'd0;
            tempo_seen_reg    <= 1'b0;
            row_valid_reg     <= '0;
            last_wr_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                unique case (stage_item_reg.kind)
                    KIND_START:
                    begin
                        program_seen_reg  <= 16'd0;
                        pressure_seen_reg <= 16'd0;
                        pitch_seen_reg    <= 16'd0;
                        tempo_seen_reg    <= 1'b0;
                        row_valid_reg     <= '0;
                        last_wr_valid_reg <= 1'b0;
                    end
                    KIND_CONTROL:
                    begin
                        row_valid_reg[stage_addr] <= 1'b1;
                        last_wr_valid_reg         <= 1'b1;
                    end
                    KIND_PROGRAM:  program_seen_reg  <= program_seen_reg | chan_bit;
                    KIND_PRESSURE: pressure_seen_reg <= pressure_seen_reg | chan_bit;
                    KIND_PITCH:    pitch_seen_reg    <= pitch_seen_reg | chan_bit;
                    KIND_TEMPO:    tempo_seen_reg    <= 1'b1;
                    default:       tempo_seen_reg    <= tempo_seen_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_item_reg <= head.item;
        end
        if (ram_wr_en)
        begin
            last_wr_addr_reg <= stage_addr;
            last_wr_data_reg <= ram_wr_data;
        end
        if (fire)
        begin
            keep_reg      <= keep_now;
            event_out_reg <= stage_item_reg.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;
    assign event_out = event_out_reg;

endmodule

@@ design/midi_seek_key_event_filter_core.sv @@
// Top level of the MIDI seek key-event filter: front end, queue and back end.
// Depends on mskef_pkg, mskef_front, mskef_queue, mskef_back and mskef_ram.
//
// This block takes stream event words walked backwards in time from a seek
// point and marks which of them must be replayed as key events: the most
// recent control change per controller and channel, the most recent program
// change, channel pressure and pitch wheel per channel, and the most recent
// tempo event. Each word comes out once, unchanged, with a keep flag, in the
// order it went in. A word with seek_start set clears every mark and is always
// kept. The block takes one word per clock cycle while in_stall is low; a word
// passes through the queue, the stage register and the output register. The front
// end classifies each word into a two-entry queue, and the back end reads the
// controller's channel bitmap from a RAM, decides keep and writes the bitmap
// back, forwarding the last write so that back-to-back words on the same
// controller see each other. A per-row valid bit makes the seek-start clear
// take effect at once, so no clearing pass is needed after reset or a seek.
// The tempo code register is written through cfg_write_en and cfg_write_data
// and must only be changed while no word is in flight.
module midi_seek_key_event_filter_core
    import mskef_pkg::*;
#(
    parameter int NUM_CONTROLLERS = 120
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: tempo code register.
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,

    // Input word channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] event_word,
    input  logic        seek_start,

    // Result word channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        keep,
    output logic [31:0] event_out
);

    item_t       front_item;
    logic        queue_full;
    logic        queue_push;
    logic        queue_pop;
    queue_head_t queue_head;

    // The front end only stalls when the queue has no room left.
    assign in_stall   = queue_full;
    assign queue_push = in_valid && !queue_full;

    mskef_front #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .event_word     (event_word),
        .seek_start     (seek_start),
        .item           (front_item)
    );

    mskef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (queue_head)
    );

    mskef_back #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (queue_head),
        .pop       (queue_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .keep      (keep),
        .event_out (event_out)
    );

endmodule

@@ test/midi_seek_key_event_filter_core_tb.sv @@
// Self-checking testbench for midi_seek_key_event_filter_core.
// Depends on mskef_pkg and the design files; a directed table and random
// phases are checked word by word against a keep predictor or table answers.
module midi_seek_key_event_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mskef_pkg::*;

    localparam int NUM_CTRL    = 120;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_WORDS = 110;
    localparam int IDLE_PCT    = 28;

    // One row of the directed table: either a word to send or a write of the
    // tempo code register. When typed is set, keep is the known answer;
    // otherwise the predictor decides.
    typedef enum logic {ROW_WORD, ROW_CONFIG} row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [31:0] word;
        logic        start;
        logic        typed;
        logic        keep;
    } row_t;

    // What the block should hand back for one accepted word.
    typedef struct packed {
        logic        keep;
        logic [31:0] word;
    } filter_result_t;

    typedef struct packed {
        logic [31:0] word;
        logic        start;
    } stim_t;

    localparam int NUM_ROWS = 27;
    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Tempo code is at its reset value of 1 here.
        '{ROW_WORD,   32'h0000_00B0, 1'b0, 1'b1, 1'b1}, // first control change after reset
        '{ROW_WORD,   32'h0000_00B0, 1'b0, 1'b1, 1'b0}, // same controller and channel again
        '{ROW_WORD,   32'h0000_77BF, 1'b0, 1'b1, 1'b1}, // highest controller, channel 15
        '{ROW_WORD,   32'h0000_78B0, 1'b0, 1'b1, 1'b0}, // controller 120 is out of range
        '{ROW_WORD,   32'h0000_FFB5, 1'b0, 1'b1, 1'b0}, // controller 255 is out of range
        '{ROW_WORD,   32'h0000_00C3, 1'b0, 1'b1, 1'b1}, // program change, channel 3
        '{ROW_WORD,   32'h0000_45C3, 1'b0, 1'b0, 1'b0}, // program change repeated
        '{ROW_WORD,   32'h0000_12DF, 1'b0, 1'b1, 1'b1}, // channel pressure, channel 15
        '{ROW_WORD,   32'h00FF_FFE0, 1'b0, 1'b0, 1'b0}, // pitch wheel, upper bytes set
        '{ROW_WORD,   32'h0000_7F90, 1'b0, 1'b1, 1'b0}, // note on is dropped
        '{ROW_WORD,   32'h0000_4080, 1'b0, 1'b1, 1'b0}, // note off is dropped
        '{ROW_WORD,   32'h0000_1AA7, 1'b0, 1'b1, 1'b0}, // poly pressure is dropped
        '{ROW_WORD,   32'h0000_00F0, 1'b0, 1'b1, 1'b0}, // system status is dropped
        '{ROW_WORD,   32'h0000_00FF, 1'b0, 1'b1, 1'b0}, // system reset status is dropped
        '{ROW_WORD,   32'h0123_4567, 1'b0, 1'b1, 1'b1}, // first tempo event
        '{ROW_WORD,   32'h01FF_FFFF, 1'b0, 1'b1, 1'b0}, // second tempo event
        '{ROW_WORD,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0}, // unknown type
        '{ROW_WORD,   32'h0200_00B1, 1'b0, 1'b1, 1'b0}, // control status under another type
        '{ROW_WORD,   32'h0000_0090, 1'b1, 1'b1, 1'b1}, // seek start on a note word
        '{ROW_WORD,   32'h0000_00B0, 1'b0, 1'b0, 1'b0}, // marks were cleared by the seek
        '{ROW_WORD,   32'h0100_0000, 1'b0, 1'b0, 1'b0}, // tempo mark was cleared too
        '{ROW_WORD,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}, // seek start, all ones
        '{ROW_CONFIG, 32'h0000_0000, 1'b0, 1'b0, 1'b0}, // tempo code zero
        '{ROW_WORD,   32'h0000_0000, 1'b0, 1'b1, 1'b0}, // type 0 stays a short message
        '{ROW_WORD,   32'h0000_01B2, 1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, 32'h0000_00FF, 1'b0, 1'b0, 1'b0}, // highest tempo code
        '{ROW_WORD,   32'hFF00_FFFF, 1'b0, 1'b0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic [7:0]  cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] event_word;
    logic        seek_start;
    logic        out_valid;
    logic        out_stall;
    logic        keep;
    logic [31:0] event_out;

    midi_seek_key_event_filter_core #(
        .NUM_CONTROLLERS(NUM_CTRL)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .event_word    (event_word),
        .seek_start    (seek_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .keep          (keep),
        .event_out     (event_out)
    );

    always #5 clk = ~clk;

    // Predictor state: a copy of the tempo code and of every seen mark.
    logic [7:0]  tempo_type;
    logic [15:0] control_marks [NUM_CTRL];
    logic [15:0] program_marks;
    logic [15:0] pressure_marks;
    logic [15:0] pitch_marks;
    logic        tempo_mark;

    // Results still owed by the block, oldest first.
    filter_result_t pending_results [$];

    int  errors;
    int  words_sent;
    int  words_kept;
    int  seek_count;
    int  configs_written;
    int  cycle_count;

    // quiet turns off random idling on both sides. rx_hold_go asks the
    // receiver to hold off; it then counts the stretch down by itself.
    bit  quiet;
    bit  rx_hold_go;
    int  hold_left;

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Decides keep for one word and updates the marks, exactly as the block
    // should. Type 0 is checked before the tempo code, so a tempo code of
    // zero never produces a tempo event.
    function automatic logic chase_keep(input logic [31:0] word, input logic start);
        kind_t      kind;
        logic [3:0] chan;
        logic [7:0] data1;
        logic       kept;
        kind  = KIND_DROP;
        chan  = word[3:0];
        data1 = word[15:8];
        kept  = 1'b0;
        if (start)
        begin
            kind = KIND_START;
        end
        else if (word[31:24] == SHORT_MSG_TYPE)
        begin
            case (word[7:4])
                STATUS_CONTROL:  if (data1 < NUM_CTRL) kind = KIND_CONTROL;
                STATUS_PROGRAM:  kind = KIND_PROGRAM;
                STATUS_PRESSURE: kind = KIND_PRESSURE;
                STATUS_PITCH:    kind = KIND_PITCH;
                default:         kind = KIND_DROP;
            endcase
        end
        else if (word[31:24] == tempo_type)
        begin
            kind = KIND_TEMPO;
        end

        case (kind)
            KIND_START:
            begin
                foreach (control_marks[i]) control_marks[i] = '0;
                program_marks  = '0;
                pressure_marks = '0;
                pitch_marks    = '0;
                tempo_mark     = 1'b0;
                kept           = 1'b1;
            end
            KIND_CONTROL:
            begin
                kept = !control_marks[data1][chan];
                control_marks[data1][chan] = 1'b1;
            end
            KIND_PROGRAM:
            begin
                kept = !program_marks[chan];
                program_marks[chan] = 1'b1;
            end
            KIND_PRESSURE:
            begin
                kept = !pressure_marks[chan];
                pressure_marks[chan] = 1'b1;
            end
            KIND_PITCH:
            begin
                kept = !pitch_marks[chan];
                pitch_marks[chan] = 1'b1;
            end
            KIND_TEMPO:
            begin
                kept = !tempo_mark;
                tempo_mark = 1'b1;
            end
            default: kept = 1'b0;
        endcase
        return kept;
    endfunction

    // Random stream content. Most words are the tracked short messages on a
    // few channels and controllers so that repeats hit existing marks; the
    // rest are tempo events, other types, seek starts and plain noise.
    function automatic stim_t random_event();
        stim_t      s;
        int         pick;
        logic [3:0] nib;
        logic [3:0] chan;
        logic [7:0] data1;
        pick    = $urandom_range(0, 99);
        s.start = 1'b0;
        if (pick < 3)
        begin
            s.start = 1'b1;
            s.word  = $urandom;
        end
        else if (pick < 13)
        begin
            s.word = $urandom;
        end
        else if (pick < 19)
        begin
            s.word = {tempo_type, 24'($urandom)};
        end
        else if (pick < 22)
        begin
            s.word = {8'($urandom_range(1, 255)), 24'($urandom)};
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: nib = STATUS_CONTROL;
                3, 4:    nib = STATUS_PROGRAM;
                5:       nib = STATUS_PRESSURE;
                6, 7:    nib = STATUS_PITCH;
                default: nib = 4'($urandom_range(8, 15));
            endcase
            chan = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: data1 = 8'($urandom_range(0, 7));
                6, 7, 8:          data1 = 8'($urandom_range(0, 127));
                default:          data1 = 8'($urandom_range(120, 255));
            endcase
            s.word = {SHORT_MSG_TYPE, 8'($urandom), data1, nib, chan};
        end
        return s;
    endfunction

    // Offers one word, waits until the block takes it, then records what the
    // block owes for it. Valid stays high into the next word unless an idle
    // cycle is drawn, so each step sees at most one assignment to it.
    task automatic send_word(input logic [31:0] w, input logic s,
                             input logic typed, input logic typed_keep);
        logic predicted;
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        event_word <= w;
        seek_start <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = chase_keep(w, s);
        pending_results.push_back('{keep: typed ? typed_keep : predicted, word: w});
        words_sent++;
        if (s) seek_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_tempo(input logic [7:0] code);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= code;
        @(posedge clk);
        tempo_type = code;
        cfg_write_en <= 1'b0;
        configs_written++;
    endtask

    // Receiver: checks every accepted result against the oldest expectation
    // and draws its stall for the next cycle. A hold-off request overrides
    // random stalling for a fixed stretch.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: keep %0b event_out %08h", keep, event_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (keep !== want.keep)
                begin
                    $error("keep: expected %0b, got %0b (word %08h)", want.keep, keep, want.word);
                    errors++;
                end
                if (event_out !== want.word)
                begin
                    $error("event_out: expected %08h, got %08h", want.word, event_out);
                    errors++;
                end
                if (keep === 1'b1) words_kept++;
            end
        end
        if (rx_hold_go)
        begin
            hold_left  = HOLD_CYCLES;
            rx_hold_go = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= idle_now();
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] phase_codes [5];
        stim_t      s;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        event_word     = '0;
        seek_start     = 1'b0;
        out_stall      = 1'b0;
        errors          = 0;
        words_sent      = 0;
        words_kept      = 0;
        seek_count      = 0;
        configs_written = 0;
        cycle_count     = 0;
        quiet           = 1'b0;
        rx_hold_go      = 1'b0;
        hold_left       = 0;

        // Predictor starts from the reset state of the block.
        tempo_type = TEMPO_CODE_RESET;
        foreach (control_marks[i]) control_marks[i] = '0;
        program_marks  = '0;
        pressure_marks = '0;
        pitch_marks    = '0;
        tempo_mark     = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, every message kind and the special cases.
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].op == ROW_CONFIG)
            begin
                drain_results();
                write_tempo(DIRECTED_ROWS[i].word[7:0]);
            end
            else
            begin
                send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].start,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].keep);
            end
        end

        // Random phases, each under its own tempo code. The marks carry over
        // from one phase to the next, as the block keeps them across writes.
        phase_codes[0] = TEMPO_CODE_RESET;
        phase_codes[1] = 8'h00;
        phase_codes[2] = 8'hFF;
        phase_codes[3] = 8'($urandom_range(2, 254));
        phase_codes[4] = 8'h80;
        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            write_tempo(phase_codes[p]);
            // Phase 1 opens with a long receiver hold-off while the sender
            // keeps offering words back to back, so the queue fills and the
            // input stalls. Phase 2 opens with a stretch with no idling.
            if (p == 1)
            begin
                quiet      = 1'b1;
                rx_hold_go = 1'b1;
            end
            if (p == 2) quiet = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ((p == 1 && n == 30) || (p == 2 && n == 60)) quiet = 1'b0;
                // Midway through phase 0, the sender waits until every result is back.
                if (p == 0 && n == PHASE_WORDS / 2) drain_results();
                s = random_event();
                send_word(s.word, s.start, 1'b0, 1'b0);
            end
        end

        drain_results();
        // Run on idle to catch any stray result word.
        repeat (10) @(posedge clk);

        $display("Sent %0d words (%0d seek starts), %0d kept, under %0d tempo code writes",
                 words_sent, seek_count, words_kept, configs_written);
        $display("including codes 0 and 255, with receiver hold-off and sender drain pauses.");
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ midi_seek_key_event_filter_core.f @@
design/mskef_pkg.sv
design/mskef_ram.sv
design/mskef_front.sv
design/mskef_queue.sv
design/mskef_back.sv
design/midi_seek_key_event_filter_core.sv
test/midi_seek_key_event_filter_core_tb.sv
